// ----- hdl/b2b_pkg.sv -----
package b2b_pkg;

    localparam int WordW = 64;
    localparam int BlockWords = 16;

    typedef logic [WordW-1:0] t_word;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COMP_INIT,
        ST_COMP_RUN,
        ST_COMP_DONE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       store;
        logic [3:0] store_idx;
        logic       clear_block;
        logic       restart;
        logic       add_count;
        logic [7:0] count_inc;
        logic       comp_init;
        logic       final_block;
        logic       round_step;
        logic [3:0] round;
        logic       diag;
        logic       comp_done;
    } t_cmd;

    localparam logic [0:0] RegDigestLen = 1'd0;
    localparam logic [0:0] RegKeyLen    = 1'd1;

    localparam t_word HashIv [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
        64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
        64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };

    localparam logic [31:0] ParamBase = 32'h01010000;

    localparam logic [3:0] Sigma [10][16] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
          4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15},
        '{4'd14, 4'd10, 4'd4, 4'd8, 4'd9, 4'd15, 4'd13, 4'd6,
          4'd1, 4'd12, 4'd0, 4'd2, 4'd11, 4'd7, 4'd5, 4'd3},
        '{4'd11, 4'd8, 4'd12, 4'd0, 4'd5, 4'd2, 4'd15, 4'd13,
          4'd10, 4'd14, 4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        '{4'd7, 4'd9, 4'd3, 4'd1, 4'd13, 4'd12, 4'd11, 4'd14,
          4'd2, 4'd6, 4'd5, 4'd10, 4'd4, 4'd0, 4'd15, 4'd8},
        '{4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10, 4'd15,
          4'd14, 4'd1, 4'd11, 4'd12, 4'd6, 4'd8, 4'd3, 4'd13},
        '{4'd2, 4'd12, 4'd6, 4'd10, 4'd0, 4'd11, 4'd8, 4'd3,
          4'd4, 4'd13, 4'd7, 4'd5, 4'd15, 4'd14, 4'd1, 4'd9},
        '{4'd12, 4'd5, 4'd1, 4'd15, 4'd14, 4'd13, 4'd4, 4'd10,
          4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        '{4'd13, 4'd11, 4'd7, 4'd14, 4'd12, 4'd1, 4'd3, 4'd9,
          4'd5, 4'd0, 4'd15, 4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        '{4'd6, 4'd15, 4'd14, 4'd9, 4'd11, 4'd3, 4'd0, 4'd8,
          4'd12, 4'd2, 4'd13, 4'd7, 4'd1, 4'd4, 4'd10, 4'd5},
        '{4'd10, 4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
          4'd15, 4'd11, 4'd9, 4'd14, 4'd3, 4'd12, 4'd13, 4'd0}
    };

    function automatic t_word rotr(input t_word x, input int n);
        return (x >> n) | (x << (WordW - n));
    endfunction

endpackage

// ----- hdl/blake2b_hash_engine_top.sv -----
// BLAKE2b hash engine: 64-bit little-endian message words in, digest words out.
// Words are accepted only while the engine is idle; the word after a full
// 16-word block, and the last word, start a compression of 12 rounds run as
// 24 half-round steps on four shared G units. A compression keeps the input
// closed through its load, 24 steps and fold into the chain value. A last word
// with data that follows a full block costs two compressions back to back.
// After the last word ceil(digest_length/8) digest words are sent, one per
// accepted transfer, then the engine restarts. A register write while idle
// abandons any message in progress. The held block is filled in place and the
// next word is stored into the cleared block after the compression that it triggers.
module blake2b_hash_engine_top
    import b2b_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [63:0] i_message_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_digest_word,
    output logic [3:0]  o_digest_bytes,
    output logic        o_last_word
);

    logic [6:0] r_dig_len, r_key_len, dl, kl;
    logic [63:0] r_word, masked;
    logic [3:0] cnt;
    t_cmd cmd, dp_cmd;
    logic [2:0] out_idx;
    logic [3:0] out_bytes;
    t_word chain_word;
    logic [6:0] n_dig_len, n_key_len;

    always_comb begin
        n_dig_len = r_dig_len;
        n_key_len = r_key_len;
        if (i_cfg_we) begin
            if (i_cfg_index == RegDigestLen) n_dig_len = i_cfg_data;
            else if (i_cfg_index == RegKeyLen) n_key_len = i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dig_len <= 7'd64;
            r_key_len <= 7'd0;
        end else begin
            r_dig_len <= n_dig_len;
            r_key_len <= n_key_len;
        end
    end

    assign dl = (n_dig_len == 7'd0) ? 7'd1 : (n_dig_len > 7'd64) ? 7'd64 : n_dig_len;
    assign kl = (n_key_len > 7'd64) ? 7'd64 : n_key_len;

    assign cnt = (!i_last_item || i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
    always_comb begin
        masked = i_message_word;
        for (int b = 0; b < 8; b++)
            if (b >= cnt) masked[b*8 +: 8] = 8'd0;
    end

    // word that triggers a full-block compression is stored after it
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_word <= masked;
        end
    end

    b2b_control u_ctrl (
        .i_clk, .i_rst_n,
        .i_cfg_write(i_cfg_we),
        .i_in_valid, .o_in_ready,
        .i_byte_count, .i_last_item,
        .i_dig_len(r_dig_len),
        .i_out_ready,
        .o_out_valid,
        .o_out_bytes(out_bytes),
        .o_out_last(o_last_word),
        .o_out_idx(out_idx),
        .o_cmd(cmd)
    );

    always_comb begin
        dp_cmd = cmd;
        if (cmd.comp_done && cmd.clear_block) begin
            dp_cmd.store = 1'b1;
            dp_cmd.store_idx = 4'd0;
        end
    end

    // clear and store of the delayed word happen together: store wins at index 0
    b2b_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_cmd(dp_cmd),
        .i_word(cmd.store ? masked : r_word),
        .i_dig_len(dl),
        .i_key_len(kl),
        .i_out_idx(out_idx),
        .o_chain_word(chain_word)
    );

    always_comb begin
        o_digest_word = chain_word;
        for (int b = 0; b < 8; b++)
            if (b >= out_bytes) o_digest_word[b*8 +: 8] = 8'd0;
    end
    assign o_digest_bytes = out_bytes;

endmodule

// ----- hdl/b2b_datapath.sv -----
module b2b_datapath
    import b2b_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    input  t_word      i_word,
    input  logic [6:0] i_dig_len,
    input  logic [6:0] i_key_len,
    input  logic [2:0] i_out_idx,
    output t_word      o_chain_word
);

    t_word r_h [8];
    t_word r_v [16];
    t_word r_m [16];
    logic [63:0] r_cnt_lo;
    logic [63:0] r_cnt_hi;

    t_word       n_v [16];
    logic [64:0] cnt_sum;
    logic [3:0]  round_mod;
    t_word       param_word;

    assign cnt_sum = {1'b0, r_cnt_lo} + {57'd0, i_cmd.count_inc};
    assign round_mod = (i_cmd.round >= 4'd10) ? i_cmd.round - 4'd10 : i_cmd.round;
    assign param_word = {32'd0, ParamBase} | {48'd0, 1'b0, i_key_len, 1'b0, i_dig_len};

    // four parallel G functions, one half round per cycle
    always_comb begin
        t_word a, b, c, d, x, y;
        int ia, ib, ic, id;
        n_v = r_v;
        for (int g = 0; g < 4; g++) begin
            ia = g;
            ib = i_cmd.diag ? 4 + ((g + 1) % 4) : 4 + g;
            ic = i_cmd.diag ? 8 + ((g + 2) % 4) : 8 + g;
            id = i_cmd.diag ? 12 + ((g + 3) % 4) : 12 + g;
            x = r_m[Sigma[round_mod][(i_cmd.diag ? 8 : 0) + 2 * g]];
            y = r_m[Sigma[round_mod][(i_cmd.diag ? 8 : 0) + 2 * g + 1]];
            a = r_v[ia]; b = r_v[ib]; c = r_v[ic]; d = r_v[id];
            a = a + b + x;
            d = rotr(d ^ a, 32);
            c = c + d;
            b = rotr(b ^ c, 24);
            a = a + b + y;
            d = rotr(d ^ a, 16);
            c = c + d;
            b = rotr(b ^ c, 63);
            n_v[ia] = a; n_v[ib] = b; n_v[ic] = c; n_v[id] = d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.restart) begin
            for (int i = 0; i < 8; i++)
                r_h[i] <= (i == 0) ? (HashIv[0] ^ param_word) : HashIv[i];
            r_cnt_lo <= '0;
            r_cnt_hi <= '0;
            for (int i = 0; i < 16; i++) r_m[i] <= '0;
        end else begin
            // store wins over clear at its own index
            for (int i = 0; i < 16; i++) begin
                if (i_cmd.store && i_cmd.store_idx == 4'(i)) r_m[i] <= i_word;
                else if (i_cmd.clear_block) r_m[i] <= '0;
            end
            if (i_cmd.add_count) begin
                r_cnt_lo <= cnt_sum[63:0];
                r_cnt_hi <= r_cnt_hi + {63'd0, cnt_sum[64]};
            end
            if (i_cmd.comp_done) begin
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i + 8];
            end
        end
    end

    // counter already updated when init runs
    always_ff @(posedge i_clk) begin
        if (i_cmd.comp_init) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            for (int i = 0; i < 4; i++) r_v[i + 8] <= HashIv[i];
            r_v[12] <= HashIv[4] ^ r_cnt_lo;
            r_v[13] <= HashIv[5] ^ r_cnt_hi;
            r_v[14] <= HashIv[6] ^ {WordW{i_cmd.final_block}};
            r_v[15] <= HashIv[7];
        end else if (i_cmd.round_step) begin
            r_v <= n_v;
        end
    end

    assign o_chain_word = r_h[i_out_idx];

endmodule

// ----- hdl/b2b_control.sv -----
module b2b_control
    import b2b_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_write,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [3:0] i_byte_count,
    input  logic       i_last_item,
    input  logic [6:0] i_dig_len,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [3:0] o_out_bytes,
    output logic       o_out_last,
    output logic [2:0] o_out_idx,
    output t_cmd       o_cmd
);

    t_state r_state, n_state;
    logic [4:0] r_held, n_held;
    logic [4:0] r_step, n_step;
    logic       r_final, n_final;
    logic       r_pend_store, n_pend_store;
    logic       r_pend_last, n_pend_last;
    logic [3:0] r_pend_cnt, n_pend_cnt;
    logic [2:0] r_idx, n_idx;

    logic       acc;
    logic [3:0] cnt;
    logic [6:0] dl;
    logic [2:0] last_idx;
    logic [6:0] left;

    assign acc = i_in_valid && o_in_ready;
    assign cnt = (!i_last_item || i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
    assign dl = (i_dig_len == 7'd0) ? 7'd1 : (i_dig_len > 7'd64) ? 7'd64 : i_dig_len;
    assign last_idx = 3'((dl - 7'd1) >> 3);
    assign left = dl - {1'b0, r_idx, 3'd0};
    assign o_in_ready = (r_state == ST_IDLE) && !i_cfg_write;
    assign o_out_valid = (r_state == ST_EMIT);
    assign o_out_bytes = (left > 7'd8) ? 4'd8 : left[3:0];
    assign o_out_last = (r_idx == last_idx);
    assign o_out_idx = r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held <= '0;
            r_step <= '0;
            r_final <= 1'b0;
            r_pend_store <= 1'b0;
            r_pend_last <= 1'b0;
            r_pend_cnt <= '0;
            r_idx <= '0;
        end else begin
            r_state <= n_state;
            r_held <= n_held;
            r_step <= n_step;
            r_final <= n_final;
            r_pend_store <= n_pend_store;
            r_pend_last <= n_pend_last;
            r_pend_cnt <= n_pend_cnt;
            r_idx <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_held = r_held;
        n_step = r_step;
        n_final = r_final;
        n_pend_store = r_pend_store;
        n_pend_last = r_pend_last;
        n_pend_cnt = r_pend_cnt;
        n_idx = r_idx;
        o_cmd = '0;
        o_cmd.store_idx = r_held[3:0];
        o_cmd.round = r_step[4:1];
        o_cmd.diag = r_step[0];
        o_cmd.final_block = r_final;
        unique case (r_state)
            ST_IDLE: begin
                if (i_cfg_write) begin
                    o_cmd.restart = 1'b1;
                    n_held = '0;
                end else if (acc) begin
                    if (cnt != 4'd0 && r_held == 5'd16) begin
                        // full block waits until more data arrives
                        o_cmd.add_count = 1'b1;
                        o_cmd.count_inc = 8'd128;
                        n_final = 1'b0;
                        n_pend_store = 1'b1;
                        n_pend_last = i_last_item;
                        n_pend_cnt = cnt;
                        n_state = ST_COMP_INIT;
                    end else begin
                        if (cnt != 4'd0) begin
                            o_cmd.store = 1'b1;
                            n_held = r_held + 5'd1;
                        end
                        if (i_last_item) begin
                            o_cmd.add_count = 1'b1;
                            o_cmd.count_inc = {r_held, 3'b0} + {4'd0, cnt};
                            n_final = 1'b1;
                            n_pend_store = 1'b0;
                            n_state = ST_COMP_INIT;
                        end
                    end
                end
            end
            ST_COMP_INIT: begin
                o_cmd.comp_init = 1'b1;
                n_step = '0;
                n_state = ST_COMP_RUN;
            end
            ST_COMP_RUN: begin
                o_cmd.round_step = 1'b1;
                n_step = r_step + 5'd1;
                if (r_step == 5'd23) n_state = ST_COMP_DONE;
            end
            ST_COMP_DONE: begin
                o_cmd.comp_done = 1'b1;
                if (r_pend_store) begin
                    // held word goes to slot 0 of the cleared block
                    o_cmd.clear_block = 1'b1;
                    n_held = 5'd1;
                    n_pend_store = 1'b0;
                    if (r_pend_last) begin
                        o_cmd.add_count = 1'b1;
                        o_cmd.count_inc = {4'd0, r_pend_cnt};
                        n_final = 1'b1;
                        n_pend_last = 1'b0;
                        n_state = ST_COMP_INIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end else begin
                    n_idx = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_out_ready) begin
                    n_idx = r_idx + 3'd1;
                    if (o_out_last) begin
                        o_cmd.restart = 1'b1;
                        n_held = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_held_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= 5'd16) else $error("held count overflow");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> !o_in_ready) else $error("accept while busy");
    a_run_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_COMP_INIT |=> r_state == ST_COMP_RUN && r_step == 5'd0)
        else $error("compression start");
`endif

endmodule
